// ===== rtl/pgntok_pkg.sv =====
`default_nettype none
package pgntok_pkg;

  localparam int MAX_TOKEN  = 8;
  localparam int MAX_DEPTH  = 255;
  localparam int CHAR_W     = 8;
  localparam int TEXT_W     = 64;
  localparam int CNT_W      = 4;
  localparam int IDX_W      = $clog2(MAX_TOKEN);
  localparam int DEPTH_W    = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

  // Result markers, first character in the lowest byte.
  localparam logic [TEXT_W-1:0] MARK_WHITE = 64'h0000_0000_0030_2D31;
  localparam logic [TEXT_W-1:0] MARK_BLACK = 64'h0000_0000_0031_2D30;
  localparam logic [TEXT_W-1:0] MARK_DRAW  = 64'h0032_2F31_2D32_2F31;
  localparam logic [TEXT_W-1:0] MARK_OPEN  = 64'h0000_0000_0000_002A;
  localparam logic [CNT_W-1:0]  LEN_WHITE  = 4'd3;
  localparam logic [CNT_W-1:0]  LEN_BLACK  = 4'd3;
  localparam logic [CNT_W-1:0]  LEN_DRAW   = 4'd7;
  localparam logic [CNT_W-1:0]  LEN_OPEN   = 4'd1;

  typedef enum logic [0:0] {
    KIND_MOVE   = 1'b0,
    KIND_RESULT = 1'b1
  } token_kind_t;

  // Raw token as the front ends it.
  typedef struct packed {
    logic [TEXT_W-1:0] text;
    logic [CNT_W-1:0]  count;
    logic              overflow;
    logic              has_dot;
  } tok_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/pgntok_front.sv =====
`default_nettype none
module pgntok_front
  import pgntok_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic              end_of_text,
  output logic                   push,
  output tok_rec_t               push_rec
);

  logic               comment_r, comment_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  tok_rec_t           tok_r, tok_nxt;
  tok_rec_t           app_tok;
  logic               flush_now, append, is_ws;
  logic [IDX_W-1:0]   wr_idx;

  assign wr_idx = tok_r.count[IDX_W-1:0];
  assign is_ws  = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));

  // Token as it stands once this character is appended.
  always_comb begin
    app_tok = tok_r;
    if (char_in == CH_DOT) begin
      app_tok.has_dot = 1'b1;
    end
    if (tok_r.count < CNT_W'(MAX_TOKEN)) begin
      app_tok.text[8*wr_idx +: CHAR_W] = char_in;
      app_tok.count = tok_r.count + CNT_W'(1);
    end else begin
      app_tok.overflow = 1'b1;
    end
  end

  always_comb begin
    comment_nxt = comment_r;
    depth_nxt   = depth_r;
    flush_now   = 1'b0;
    append      = 1'b0;
    if (comment_r) begin
      if (char_in == CH_RBRACE) begin
        comment_nxt = 1'b0;
      end
    end else if (char_in == CH_LBRACE) begin
      flush_now   = 1'b1;
      comment_nxt = 1'b1;
    end else if (char_in == CH_LPAREN) begin
      flush_now = 1'b1;
      if (depth_r < DEPTH_W'(MAX_DEPTH)) begin
        depth_nxt = depth_r + DEPTH_W'(1);
      end
    end else if (char_in == CH_RPAREN) begin
      flush_now = 1'b1;
      if (depth_r != '0) begin
        depth_nxt = depth_r - DEPTH_W'(1);
      end
    end else if (depth_r != '0) begin
      // drop inside a variation
    end else if (is_ws) begin
      flush_now = 1'b1;
    end else begin
      append = 1'b1;
    end

    push_rec = append ? app_tok : tok_r;
    push     = accept && (flush_now || end_of_text) && (push_rec.count != '0);

    if (flush_now || end_of_text) begin
      tok_nxt = '0;
    end else if (append) begin
      tok_nxt = app_tok;
    end else begin
      tok_nxt = tok_r;
    end
    if (end_of_text) begin
      comment_nxt = 1'b0;
      depth_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comment_r <= 1'b0;
      depth_r   <= '0;
      tok_r     <= '0;
    end else if (accept) begin
      comment_r <= comment_nxt;
      depth_r   <= depth_nxt;
      tok_r     <= tok_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pgntok_queue.sv =====
`default_nettype none
module pgntok_queue
  import pgntok_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tok_rec_t push_rec,
  input  wire logic     pop,
  output tok_rec_t      pop_rec,
  output q_stat_t       stat
);

  tok_rec_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_rec    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pgntok_back.sv =====
`default_nettype none
module pgntok_back
  import pgntok_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tok_rec_t          q_rec,
  input  wire q_stat_t           q_stat,
  output logic                   pop,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   token_kind,
  output logic [TEXT_W-1:0]      token_text,
  output logic [CNT_W-1:0]       token_length,
  output logic                   token_truncated
);

  logic              valid_r, valid_nxt;
  logic              kind_r;
  logic [TEXT_W-1:0] text_r;
  logic [CNT_W-1:0]  len_r;
  logic              trunc_r;
  logic              out_free, is_result, is_nag, emit;

  assign out_free = !valid_r || !out_stall;
  assign pop      = !q_stat.empty && out_free;

  always_comb begin
    is_result = !q_rec.overflow && (
        (q_rec.count == LEN_WHITE && q_rec.text == MARK_WHITE) ||
        (q_rec.count == LEN_BLACK && q_rec.text == MARK_BLACK) ||
        (q_rec.count == LEN_DRAW  && q_rec.text == MARK_DRAW)  ||
        (q_rec.count == LEN_OPEN  && q_rec.text == MARK_OPEN));
    is_nag = (q_rec.text[CHAR_W-1:0] == CH_DOLLAR);
    emit   = is_result || (!q_rec.has_dot && !is_nag);

    valid_nxt = valid_r;
    if (pop && emit) begin
      valid_nxt = 1'b1;
    end else if (out_free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind_r  <= is_result ? KIND_RESULT : KIND_MOVE;
      text_r  <= q_rec.text;
      len_r   <= q_rec.count;
      trunc_r <= q_rec.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign token_kind      = kind_r;
  assign token_text      = text_r;
  assign token_length    = len_r;
  assign token_truncated = trunc_r;

endmodule
`default_nettype wire

// ===== rtl/game_notation_movetext_tokenizer_unit.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_char_in[7:0], in_end_of_text
// out     | output    | out_valid/out_stall| out_token_kind, out_token_text[63:0],
//         |           |                    | out_token_length[3:0], out_token_truncated
//
// One character item is taken every cycle while in_stall is low; the front updates
// comment, depth and token state in that cycle. A finished token passes through the
// four-entry queue and then the output register before it reaches out_valid.
// in_stall rises only while the queue is full, i.e. after out_stall has held off
// the back for several tokens; dropped tokens (move numbers, glyphs) are popped but
// never reach the output. Reset is synchronous on rst_n and needs no clearing pass.
`default_nettype none
module game_notation_movetext_tokenizer_unit
  import pgntok_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAR_W-1:0] in_char_in,
  input  wire logic              in_end_of_text,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_token_kind,
  output logic [TEXT_W-1:0]      out_token_text,
  output logic [CNT_W-1:0]       out_token_length,
  output logic                   out_token_truncated
);

  logic     in_accept;
  logic     q_push, q_pop;
  tok_rec_t q_push_rec, q_pop_rec;
  q_stat_t  q_stat;

  // Hold the input whenever the queue cannot take one more token.
  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;

  // Front: classify each character and end tokens.
  pgntok_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .char_in     (in_char_in),
    .end_of_text (in_end_of_text),
    .push        (q_push),
    .push_rec    (q_push_rec)
  );

  // Decouple the front from output back-pressure.
  pgntok_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_push_rec),
    .pop      (q_pop),
    .pop_rec  (q_pop_rec),
    .stat     (q_stat)
  );

  // Back: drop move numbers and glyphs, tag result markers, drive the output.
  pgntok_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rec           (q_pop_rec),
    .q_stat          (q_stat),
    .pop             (q_pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .token_kind      (out_token_kind),
    .token_text      (out_token_text),
    .token_length    (out_token_length),
    .token_truncated (out_token_truncated)
  );

endmodule
`default_nettype wire

// ===== rtl/pgntok_checker.sv =====
`default_nettype none
module pgntok_checker
  import pgntok_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_token_kind,
  input wire logic [TEXT_W-1:0] out_token_text,
  input wire logic [CNT_W-1:0]  out_token_length,
  input wire logic              out_token_truncated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_text_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_token_text) && $stable(out_token_length))
    else $error("token changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_length != '0 && out_token_length <= CNT_W'(MAX_TOKEN))
    else $error("token length out of range");

  a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind |-> !out_token_truncated &&
      (out_token_length == LEN_OPEN || out_token_length == LEN_WHITE ||
       out_token_length == LEN_DRAW))
    else $error("result marker with bad shape");

  a_trunc_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_truncated |-> out_token_length == CNT_W'(MAX_TOKEN))
    else $error("truncated token not full length");

endmodule

bind game_notation_movetext_tokenizer_unit pgntok_checker u_pgntok_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_token_kind      (out_token_kind),
  .out_token_text      (out_token_text),
  .out_token_length    (out_token_length),
  .out_token_truncated (out_token_truncated)
);
`default_nettype wire
